// File: hw/rtl/mrqt_pkg.sv
// shared types and constants of the quarter-turn matrix rotator
package mrqt_pkg;

  localparam int MAX_DIM   = 64;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int TURN_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURNS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CCW   = 2'd3;

  // item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // net rotation codes
  localparam logic [TURN_W-1:0] TURN_NONE = 2'd0;
  localparam logic [TURN_W-1:0] TURN_CW   = 2'd1;
  localparam logic [TURN_W-1:0] TURN_HALF = 2'd2;
  localparam logic [TURN_W-1:0] TURN_CCW  = 2'd3;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
  } mrqt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic [DIM_W-1:0]         out_cols;
    logic                     last;
  } mrqt_out_t;

  // 0 counts as 1, anything above MAX_DIM counts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    res = d;
    if (d == '0) res = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    return res;
  endfunction

endpackage

// File: hw/rtl/mrqt_ram.sv
// generic single-port-write, single-port-read ram with registered read
module mrqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/matrix_rotate_quarter_turns.sv
// quarter-turn matrix rotator: frame store in one ram, rotated read-out
//
// usage: set cols, rows, quarter_turns and counter_clockwise through the
// cfg port (cfg_we, cfg_index, cfg_wdata); any register write restarts the
// frame. an item is transferred when start is high and busy is low; busy
// stays low, so one item can be taken every cycle.
// a write item (operation 0) stores the next element in row-major order;
// writes beyond rows*cols are dropped until the frame has been read out.
// a read item (operation 1) on a complete frame returns the next element of
// the rotated matrix: out_valid is high for exactly one cycle, the cycle
// after the read transfer, with value_res, out_cols and last on out_item.
// a read on an incomplete frame gives no result and changes nothing.
// after the element flagged last the block is ready for the next frame.
// the result comes from the registered read port of the frame ram;
// throughput is one item per cycle since each item makes one ram access.
// reset clears the counters and loads cols=1, rows=1, no rotation; the ram
// contents are not cleared and there is no clearing pass. results cannot
// be held off: the receiver must take out_item in the cycle it is shown.
module matrix_rotate_quarter_turns (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  mrqt_pkg::mrqt_in_t                  in_item,
  output logic                                out_valid,
  output mrqt_pkg::mrqt_out_t                 out_item,
  input  logic                                cfg_we,
  input  logic [mrqt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrqt_pkg::CFG_W-1:0]          cfg_wdata
);
  import mrqt_pkg::*;

  // configuration
  logic [DIM_W-1:0]  cols_r, rows_r;
  logic [TURN_W-1:0] qturns_r;
  logic              ccw_r;

  // frame counters
  logic [CNT_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]  rd_row_r, rd_row_nxt;
  logic [IDX_W-1:0]  rd_col_r, rd_col_nxt;

  // result stage
  logic              out_valid_r;
  logic [DIM_W-1:0]  out_cols_r;
  logic              out_last_r;

  logic [DIM_W-1:0]  nc, nr, ocols;
  logic [IDX_W-1:0]  nc_m1, nr_m1, orows_m1, ocols_m1;
  logic [TURN_W-1:0] turns;
  logic [CNT_W-1:0]  total;
  logic              frame_full;
  logic              in_fire, wr_fire, rd_fire, is_last;
  logic [IDX_W-1:0]  src_row, src_col;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] ram_rdata;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  always_comb begin
    nc       = clamp_dim(cols_r);
    nr       = clamp_dim(rows_r);
    nc_m1    = IDX_W'(nc - DIM_W'(1));
    nr_m1    = IDX_W'(nr - DIM_W'(1));
    turns    = ccw_r ? TURN_W'(-qturns_r) : qturns_r;
    ocols    = turns[0] ? nr : nc;
    ocols_m1 = turns[0] ? nr_m1 : nc_m1;
    orows_m1 = turns[0] ? nc_m1 : nr_m1;
    total    = CNT_W'(nr) * CNT_W'(nc);
  end

  assign frame_full = (wr_idx_r >= total);
  assign wr_fire    = in_fire && (in_item.operation == OP_WRITE) && !frame_full;
  assign rd_fire    = in_fire && (in_item.operation == OP_READ) && frame_full;
  assign is_last    = (rd_row_r == orows_m1) && (rd_col_r == ocols_m1);

  // map the rotated position back to the stored element
  always_comb begin
    case (turns)
      TURN_CW: begin
        src_row = nr_m1 - rd_col_r;
        src_col = rd_row_r;
      end
      TURN_HALF: begin
        src_row = nr_m1 - rd_row_r;
        src_col = nc_m1 - rd_col_r;
      end
      TURN_CCW: begin
        src_row = rd_col_r;
        src_col = nc_m1 - rd_row_r;
      end
      default: begin
        src_row = rd_row_r;
        src_col = rd_col_r;
      end
    endcase
    rd_addr = ADDR_W'(src_row) * ADDR_W'(nc) + ADDR_W'(src_col);
  end

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_row_nxt = rd_row_r;
    rd_col_nxt = rd_col_r;
    if (cfg_we) begin
      wr_idx_nxt = '0;
      rd_row_nxt = '0;
      rd_col_nxt = '0;
    end else if (wr_fire) begin
      wr_idx_nxt = wr_idx_r + CNT_W'(1);
    end else if (rd_fire) begin
      if (is_last) begin
        wr_idx_nxt = '0;
        rd_row_nxt = '0;
        rd_col_nxt = '0;
      end else if (rd_col_r == ocols_m1) begin
        rd_col_nxt = '0;
        rd_row_nxt = rd_row_r + IDX_W'(1);
      end else begin
        rd_col_nxt = rd_col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= DIM_W'(1);
      rows_r      <= DIM_W'(1);
      qturns_r    <= '0;
      ccw_r       <= 1'b0;
      wr_idx_r    <= '0;
      rd_row_r    <= '0;
      rd_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLS:  cols_r   <= cfg_wdata;
          CFG_ROWS:  rows_r   <= cfg_wdata;
          CFG_TURNS: qturns_r <= cfg_wdata[TURN_W-1:0];
          CFG_CCW:   ccw_r    <= cfg_wdata[0];
          default:   ;
        endcase
      end
      wr_idx_r    <= wr_idx_nxt;
      rd_row_r    <= rd_row_nxt;
      rd_col_r    <= rd_col_nxt;
      out_valid_r <= rd_fire;
    end
  end

  // sideband travels alongside the ram read
  always_ff @(posedge clk) begin
    if (rd_fire) begin
      out_cols_r <= ocols;
      out_last_r <= is_last;
    end
  end

  mrqt_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (wr_fire),
    .waddr(wr_idx_r[ADDR_W-1:0]),
    .wdata(in_item.value),
    .re   (rd_fire),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_item.value_res = ram_rdata;
  assign out_item.out_cols  = out_cols_r;
  assign out_item.last      = out_last_r;

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(rd_fire))
    else $error("result without a read transfer");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= total)
    else $error("write count past frame size");

  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_row_r <= orows_m1) && (rd_col_r <= ocols_m1))
    else $error("read position outside rotated frame");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (rd_row_r == '0) && (rd_col_r == '0))
    else $error("frame not restarted after last element");

endmodule

// File: dv/testbench.sv
// self-checking testbench for the quarter-turn matrix rotator
`timescale 1ns / 100ps

module testbench;
  import mrqt_pkg::*;

  localparam int ITEM_GOAL   = 1950;
  localparam int CALM_ITEMS  = 1650;
  localparam int QUIET_LIMIT = 1000;
  localparam int N_DIR       = 37;
  // room needed before a full-size side is allowed
  localparam int BIG_ROOM    = 1100;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic                 op;
    logic [DATA_W-1:0]    data;
    logic                 has_res;
    mrqt_out_t            res;
  } dir_row_t;

  typedef struct {
    mrqt_out_t pred;
    logic      has_typed;
    mrqt_out_t typed;
  } pending_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  mrqt_in_t             in_item;
  logic                 out_valid;
  mrqt_out_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // typed expectation of a directed row, travels with the item
  logic                 typed_on;
  mrqt_out_t            typed_res;

  // rotator state as the testbench sees it
  logic [DATA_W-1:0]    frame_mem [0:DEPTH-1];
  logic [CFG_W-1:0]     reg_cols;
  logic [CFG_W-1:0]     reg_rows;
  logic [TURN_W-1:0]    reg_turns;
  logic                 reg_ccw;
  int                   wr_count;
  int                   rd_row;
  int                   rd_col;

  pending_t             pend_q [$];
  dir_row_t             dir_tab [N_DIR];
  int                   n_fail;
  int                   n_wr;
  int                   n_rd;
  int                   n_ign;
  int                   n_cfg;
  int                   n_frames;
  int                   quiet_cnt;
  logic                 gaps_on;

  matrix_rotate_quarter_turns u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(input logic [CFG_W-1:0] d);
    if (d == '0) return 1;
    if (d > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic int frame_size(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r);
    return eff_dim(c) * eff_dim(r);
  endfunction

  // one input item through the rotator: store a pixel or fetch a rotated one
  task automatic rotate_step(input mrqt_in_t it, output logic got, output mrqt_out_t res);
    int nc, nr, orows, ocols, sr, sc;
    logic [TURN_W-1:0] net;
    nc  = eff_dim(reg_cols);
    nr  = eff_dim(reg_rows);
    net = reg_ccw ? (TURN_W'(0) - reg_turns) : reg_turns;
    orows = net[0] ? nc : nr;
    ocols = net[0] ? nr : nc;
    got = 1'b0;
    res = '0;
    if (it.operation == OP_WRITE) begin
      if (wr_count < nr * nc) begin
        frame_mem[wr_count] = it.value;
        wr_count++;
        n_wr++;
      end else begin
        n_ign++;
      end
    end else if (wr_count < nr * nc) begin
      n_ign++;
    end else begin
      case (net)
        TURN_CW: begin
          sr = nr - 1 - rd_col;
          sc = rd_row;
        end
        TURN_HALF: begin
          sr = nr - 1 - rd_row;
          sc = nc - 1 - rd_col;
        end
        TURN_CCW: begin
          sr = rd_col;
          sc = nc - 1 - rd_row;
        end
        default: begin
          sr = rd_row;
          sc = rd_col;
        end
      endcase
      got           = 1'b1;
      res.value_res = frame_mem[sr * nc + sc];
      res.out_cols  = DIM_W'(ocols);
      res.last      = (rd_row == orows - 1) && (rd_col == ocols - 1);
      n_rd++;
      if (res.last) begin
        wr_count = 0;
        rd_row   = 0;
        rd_col   = 0;
        n_frames++;
      end else if (rd_col + 1 >= ocols) begin
        rd_col = 0;
        rd_row++;
      end else begin
        rd_col++;
      end
    end
  endtask

  function automatic void compare_res(input mrqt_out_t want, input mrqt_out_t got);
    if (got.value_res !== want.value_res) begin
      $error("value_res: expected %0d, got %0d", want.value_res, got.value_res);
      n_fail++;
    end
    if (got.out_cols !== want.out_cols) begin
      $error("out_cols: expected %0d, got %0d", want.out_cols, got.out_cols);
      n_fail++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      n_fail++;
    end
  endfunction

  // check results against the oldest pending one, then track transfers
  always @(posedge clk) begin
    pending_t  p;
    logic      got;
    mrqt_out_t res;
    if (!rst_n) begin
      pend_q.delete();
      reg_cols  = CFG_W'(1);
      reg_rows  = CFG_W'(1);
      reg_turns = TURN_NONE;
      reg_ccw   = 1'b0;
      wr_count  = 0;
      rd_row    = 0;
      rd_col    = 0;
    end else begin
      if (out_valid !== 1'b0) begin
        if (pend_q.size() == 0) begin
          $error("result with nothing pending: value_res %0d", out_item.value_res);
          n_fail++;
        end else begin
          p = pend_q.pop_front();
          compare_res(p.pred, out_item);
          if (p.has_typed) compare_res(p.typed, out_item);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLS:  reg_cols  = cfg_wdata;
          CFG_ROWS:  reg_rows  = cfg_wdata;
          CFG_TURNS: reg_turns = cfg_wdata[TURN_W-1:0];
          CFG_CCW:   reg_ccw   = cfg_wdata[0];
          default: ;
        endcase
        wr_count = 0;
        rd_row   = 0;
        rd_col   = 0;
        n_cfg++;
      end
      if (start && !busy) begin
        rotate_step(in_item, got, res);
        if (got) begin
          p.pred      = res;
          p.has_typed = typed_on;
          p.typed     = typed_res;
          pend_q.push_back(p);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || cfg_we) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cnt, pend_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic send_item(input logic op, input logic [DATA_W-1:0] data,
                           input logic has, input mrqt_out_t want);
    start     <= 1'b1;
    in_item   <= '{operation: op, value: data};
    typed_on  <= has;
    typed_res <= want;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic push_item(input logic op, input logic [DATA_W-1:0] data);
    if (gaps_on && n_wr + n_rd < CALM_ITEMS && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    send_item(op, data, 1'b0, '0);
  endtask

  // stop feeding and let every pending result come out
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pend_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r,
                             input logic [TURN_W-1:0] t, input logic ccw);
    drain();
    // junk in the unused upper bits must not matter
    reg_write(CFG_COLS, c);
    reg_write(CFG_ROWS, r);
    reg_write(CFG_TURNS, CFG_W'({$urandom, t}));
    reg_write(CFG_CCW, CFG_W'({$urandom, ccw}));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim(input logic keep_small);
    int sel;
    sel = keep_small ? 9 : $urandom_range(0, 19);
    case (sel)
      0: return '0;
      1: return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
      2: return CFG_W'(MAX_DIM);
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t row_wr(input logic [DATA_W-1:0] v);
    dir_row_t row;
    row = '0;
    row.op   = OP_WRITE;
    row.data = v;
    return row;
  endfunction

  function automatic dir_row_t row_rd();
    dir_row_t row;
    row = '0;
    row.op   = OP_READ;
    row.data = '1;
    return row;
  endfunction

  function automatic dir_row_t row_chk(input logic [DATA_W-1:0] v,
                                       input logic [DIM_W-1:0] oc, input logic lst);
    dir_row_t row;
    row = row_rd();
    row.has_res       = 1'b1;
    row.res.value_res = v;
    row.res.out_cols  = oc;
    row.res.last      = lst;
    return row;
  endfunction

  initial begin
    logic [CFG_W-1:0] c, r;
    logic             prev_cfg;
    int               total, cut;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_COLS;
    cfg_wdata = '0;
    typed_on  = 1'b0;
    typed_res = '0;
    gaps_on   = 1'b0;
    n_fail    = 0;
    n_wr      = 0;
    n_rd      = 0;
    n_ign     = 0;
    n_cfg     = 0;
    n_frames  = 0;
    quiet_cnt = 0;
    dir_tab = '{
      // 1x1 frame after reset: early read, overfull write, extremes
      row_rd(), row_wr(32'h7fff_ffff), row_wr(32'h8000_0000),
      row_chk(32'h7fff_ffff, 7'd1, 1'b1),
      row_wr(32'h8000_0000), row_chk(32'h8000_0000, 7'd1, 1'b1),
      // 2 rows x 3 cols turned clockwise once
      row_cfg(CFG_COLS, 7'd3), row_cfg(CFG_ROWS, 7'd2), row_cfg(CFG_TURNS, 7'd1),
      row_cfg(CFG_CCW, 7'd0), row_rd(),
      row_wr(32'd1), row_wr(32'd2), row_wr(32'd3),
      row_wr(32'd4), row_wr(32'd5), row_wr(32'd6),
      row_chk(32'd4, 7'd2, 1'b0), row_chk(32'd1, 7'd2, 1'b0),
      row_chk(32'd5, 7'd2, 1'b0), row_chk(32'd2, 7'd2, 1'b0),
      row_chk(32'd6, 7'd2, 1'b0), row_chk(32'd3, 7'd2, 1'b1),
      // zero sizes count as one, three turns back with junk upper bits
      row_cfg(CFG_COLS, 7'd0), row_cfg(CFG_ROWS, 7'd0), row_cfg(CFG_TURNS, 7'h7f),
      row_cfg(CFG_CCW, 7'h01),
      row_wr(32'hffff_ffff), row_chk(32'hffff_ffff, 7'd1, 1'b1),
      // half turn counter-clockwise reverses the row
      row_cfg(CFG_COLS, 7'd2), row_cfg(CFG_ROWS, 7'd1), row_cfg(CFG_TURNS, 7'd2),
      row_cfg(CFG_CCW, 7'd1),
      row_wr(32'd10), row_wr(32'd20),
      row_chk(32'd20, 7'd2, 1'b0), row_chk(32'd10, 7'd2, 1'b1)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!prev_cfg) drain();
        reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].has_res, dir_tab[i].res);
      end
      prev_cfg = dir_tab[i].is_cfg;
    end

    while (n_wr + n_rd < ITEM_GOAL) begin
      // full-size sides only while there is room left for such a frame
      c = rand_dim(n_wr + n_rd + BIG_ROOM > ITEM_GOAL);
      // one side at most reaches the full size, keeps frames short
      r = rand_dim(eff_dim(c) > 8 || n_wr + n_rd + BIG_ROOM > ITEM_GOAL);
      if ($urandom_range(0, 1)) {c, r} = {r, c};
      load_config(c, r, TURN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 2) != 0);
      total   = frame_size(c, r);
      for (int f = 0; f < $urandom_range(1, 3) &&
                      (f == 0 || n_wr + n_rd + 2 * total < ITEM_GOAL); f++) begin
        case ($urandom_range(0, 9))
          0: begin
            // frame dropped half written
            cut = $urandom_range(0, total - 1);
            for (int k = 0; k < cut; k++) begin
              if ($urandom_range(0, 3) == 0) push_item(OP_READ, rand_word());
              push_item(OP_WRITE, rand_word());
            end
            break;
          end
          1: begin
            // read-out cut short by the next setting
            for (int k = 0; k < total; k++) push_item(OP_WRITE, rand_word());
            cut = (total > 1) ? $urandom_range(1, total - 1) : 0;
            for (int k = 0; k < cut; k++) push_item(OP_READ, rand_word());
            break;
          end
          default: begin
            for (int k = 0; k < total; k++) begin
              if ($urandom_range(0, 19) == 0) push_item(OP_READ, rand_word());
              push_item(OP_WRITE, rand_word());
            end
            if ($urandom_range(0, 3) == 0)
              repeat ($urandom_range(1, 3)) push_item(OP_WRITE, rand_word());
            for (int k = 0; k < total; k++) begin
              if ($urandom_range(0, 19) == 0) push_item(OP_WRITE, rand_word());
              push_item(OP_READ, rand_word());
            end
            if ($urandom_range(0, 3) == 0) push_item(OP_READ, rand_word());
          end
        endcase
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("stored %0d pixels, checked %0d rotated pixels over %0d whole frames",
             n_wr, n_rd, n_frames);
    $display("%0d ignored items, %0d register writes", n_ign, n_cfg);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
